FILE: rtl/sst_pkg.sv
// Shared types and codes for the scoped symbol table evaluator.
// No dependencies.
package sst_pkg;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  name_char;
    logic        last;
    logic [7:0]  new_kind;
    logic [15:0] new_value;
    logic        new_is_local;
  } sst_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  found_kind;
    logic [15:0] found_value;
  } sst_out_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  len;
    logic        ovf;
    logic [7:0]  kind;
    logic [15:0] value;
    logic        is_local;
  } sst_job_t;

  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_EVAL   = 3'd1;
  localparam logic [2:0] FUNC_RMLOC  = 3'd2;
  localparam logic [2:0] FUNC_CLEAN  = 3'd3;
  localparam logic [2:0] FUNC_CLRALL = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_BAD_IDENT = 3'd3;
  localparam logic [2:0] ST_BAD_NUM   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_TOO_LONG  = 3'd6;

  localparam logic [15:0] NUM_MAX = 16'hFFFF;

  function automatic logic char_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h2E;
  endfunction

endpackage

FILE: rtl/sst_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/sst_front.sv
// Front end: collects characters into a key, hands finished names to a one-entry queue.
// Depends on sst_pkg.
module sst_front #(
  parameter int NAME_CHARS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sst_pkg::sst_in_t             in_data,
  output logic                         job_valid,
  input  logic                         job_ready,
  output sst_pkg::sst_job_t            job,
  output logic [NAME_CHARS-1:0][7:0]   job_key
);
  import sst_pkg::*;

  localparam int KW = $clog2(NAME_CHARS);

  logic [NAME_CHARS-1:0][7:0] key_r, key_nxt, jkey_r;
  logic [5:0] len_r, len_nxt;
  logic ovf_r, ovf_nxt;
  logic jv_r;
  sst_job_t job_r;
  logic [7:0] c;
  logic acc;

  assign in_ready  = !jv_r || job_ready;
  assign acc       = in_valid && in_ready;
  assign job_valid = jv_r;
  assign job       = job_r;
  assign job_key   = jkey_r;

  always_comb begin
    c = in_data.name_char;
    if (c >= 8'h41 && c <= 8'h5A) begin
      c = c + 8'h20;
    end
    key_nxt = key_r;
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (len_r < 6'(NAME_CHARS)) begin
      key_nxt[len_r[KW-1:0]] = c;
      len_nxt = len_r + 6'd1;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      jv_r  <= 1'b0;
    end else begin
      jv_r <= (jv_r && !job_ready) || (acc && in_data.last);
      if (acc) begin
        key_r <= key_nxt;
        if (in_data.last) begin
          len_r <= '0;
          ovf_r <= 1'b0;
          jkey_r <= key_nxt;
          job_r <= '{func: in_data.func, len: len_nxt, ovf: ovf_nxt,
                     kind: in_data.new_kind, value: in_data.new_value,
                     is_local: in_data.new_is_local};
        end else begin
          len_r <= len_nxt;
          ovf_r <= ovf_nxt;
        end
      end
    end
  end
endmodule

FILE: rtl/sst_back.sv
// Back end: table scan, number decode, add and clear operations, result register.
// Depends on sst_pkg and sst_ram.
module sst_back #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NAME_CHARS    = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  sst_pkg::sst_job_t          job,
  input  logic [NAME_CHARS-1:0][7:0] job_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sst_pkg::sst_out_t          out_data
);
  import sst_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int KW = $clog2(NAME_CHARS);
  localparam int NW = NAME_CHARS * 8;
  localparam int RW = NW + 31;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DEC} state_t;

  state_t state_r;
  sst_job_t j_r;
  logic [NAME_CHARS-1:0][7:0] k_r;
  logic [TABLE_ENTRIES-1:0] used_r;
  logic [AW:0] iss_r;
  logic rv_r;
  logic [AW-1:0] idx_r;
  logic lm_r, gm_r, fr_r;
  logic [7:0] lk_r, gk_r;
  logic [15:0] lv_r, gv_r;
  logic [AW-1:0] fi_r;
  logic [5:0] dj_r;
  logic hex_r;
  logic [16:0] acc_r;
  logic ov_r;
  sst_out_t od_r;

  logic we;
  logic [RW-1:0] wdata, rdata;
  logic [NAME_CHARS-1:0][7:0] r_name;
  logic [5:0] r_len;
  logic r_loc;
  logic [7:0] r_kind;
  logic [15:0] r_val;
  logic r_used, r_match;
  logic bad_id;
  logic [7:0] dc;
  logic [4:0] dig;
  logic dok;
  logic [20:0] acc_nxt;
  logic is_num;
  logic too_long;

  assign job_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign {r_kind, r_val, r_loc, r_len, r_name} = rdata;
  assign r_used = used_r[idx_r];
  assign is_num = job.len != 6'd0 &&
                  (job_key[0] == 8'h24 || (job_key[0] >= 8'h30 && job_key[0] <= 8'h39));
  assign too_long = (job.func == FUNC_ADD || job.func == FUNC_EVAL) && job.ovf;

  always_comb begin
    r_match = r_used && (r_len == j_r.len);
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (6'(i) < j_r.len && r_name[i] != k_r[i]) begin
        r_match = 1'b0;
      end
    end
    bad_id = 1'b0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (6'(i) < j_r.len && !char_ok(k_r[i])) begin
        bad_id = 1'b1;
      end
    end
    if (j_r.len == 6'd1 && (k_r[0] == 8'h72 || k_r[0] == 8'h61 || k_r[0] == 8'h79)) begin
      bad_id = 1'b1;
    end
  end

  always_comb begin
    dc  = k_r[dj_r[KW-1:0]];
    dig = '0;
    dok = 1'b0;
    if (dc >= 8'h30 && dc <= 8'h39) begin
      dig = 5'(dc - 8'h30);
      dok = 1'b1;
    end else if (dc >= 8'h61 && dc <= 8'h66) begin
      dig = 5'(dc - 8'h57);
      dok = 1'b1;
    end
    if (!hex_r && dig >= 5'd10) begin
      dok = 1'b0;
    end
    if (hex_r) begin
      acc_nxt = {acc_r, 4'b0} + 21'(dig);
    end else begin
      acc_nxt = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0} + 21'(dig);
    end
  end

  assign wdata = {j_r.kind, j_r.value, j_r.is_local, j_r.len, k_r};
  assign we = (state_r == S_SCAN) && (iss_r == (AW+1)'(TABLE_ENTRIES)) && !rv_r &&
              j_r.func == FUNC_ADD && !lm_r && !(!j_r.is_local && gm_r) && fr_r;

  sst_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (fi_r),
    .wdata (wdata),
    .raddr (iss_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      ov_r    <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid && !ov_r) begin
            j_r   <= job;
            k_r   <= job_key;
            iss_r <= '0;
            rv_r  <= 1'b0;
            lm_r  <= 1'b0;
            gm_r  <= 1'b0;
            fr_r  <= 1'b0;
            hex_r <= job_key[0] == 8'h24;
            dj_r  <= (job_key[0] == 8'h24) ? 6'd1 : 6'd0;
            acc_r <= '0;
            od_r  <= '{status: too_long ? ST_TOO_LONG : ST_OK, found_kind: 8'd0,
                       found_value: 16'd0};
            if (too_long) begin
              ov_r <= 1'b1;
            end else if (job.func == FUNC_EVAL && is_num) begin
              state_r <= S_DEC;
            end else if (job.func == FUNC_ADD || job.func == FUNC_EVAL ||
                         job.func == FUNC_RMLOC || job.func == FUNC_CLEAN) begin
              state_r <= S_SCAN;
            end else begin
              if (job.func == FUNC_CLRALL) begin
                used_r <= '0;
              end
              ov_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          rv_r <= iss_r != (AW+1)'(TABLE_ENTRIES);
          if (iss_r != (AW+1)'(TABLE_ENTRIES)) begin
            idx_r <= iss_r[AW-1:0];
            iss_r <= iss_r + 1'b1;
          end
          if (rv_r) begin
            if (!r_used && !fr_r) begin
              fr_r <= 1'b1;
              fi_r <= idx_r;
            end
            if (r_match && r_loc && !lm_r) begin
              lm_r <= 1'b1;
              lk_r <= r_kind;
              lv_r <= r_val;
            end
            if (r_match && !r_loc && !gm_r) begin
              gm_r <= 1'b1;
              gk_r <= r_kind;
              gv_r <= r_val;
            end
            if (r_used && ((j_r.func == FUNC_RMLOC && r_loc) ||
                (j_r.func == FUNC_CLEAN && r_len != 6'd0 && r_name[0] == 8'h2E))) begin
              used_r[idx_r] <= 1'b0;
            end
          end else if (iss_r == (AW+1)'(TABLE_ENTRIES)) begin
            state_r <= S_IDLE;
            ov_r <= 1'b1;
            case (j_r.func)
              FUNC_ADD: begin
                if (lm_r || (!j_r.is_local && gm_r)) begin
                  od_r.status <= ST_DUPLICATE;
                end else if (!fr_r) begin
                  od_r.status <= ST_FULL;
                end else begin
                  used_r[fi_r] <= j_r.kind != 8'd0;
                  od_r.status <= bad_id ? ST_BAD_IDENT : ST_OK;
                end
              end
              FUNC_EVAL: begin
                if (lm_r) begin
                  od_r <= '{status: ST_OK, found_kind: lk_r, found_value: lv_r};
                end else if (gm_r) begin
                  od_r <= '{status: ST_OK, found_kind: gk_r, found_value: gv_r};
                end else begin
                  od_r.status <= ST_NOT_FOUND;
                end
              end
              default: begin
                od_r.status <= ST_OK;
              end
            endcase
          end
        end
        S_DEC: begin
          if (dj_r >= j_r.len) begin
            state_r <= S_IDLE;
            ov_r <= 1'b1;
            od_r <= '{status: ST_OK,
                      found_kind: (acc_r < 17'd256) ? 8'h42 : 8'h57,
                      found_value: acc_r[15:0]};
          end else if (!dok || acc_nxt > 21'(NUM_MAX)) begin
            state_r <= S_IDLE;
            ov_r <= 1'b1;
            od_r.status <= ST_BAD_NUM;
          end else begin
            acc_r <= acc_nxt[16:0];
            dj_r  <= dj_r + 6'd1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/scoped_symbol_table_evaluator.sv
// Top level of the scoped symbol table evaluator: front end, job queue, back end.
// Depends on sst_pkg, sst_front, sst_back.
//
//   channel | ports                          | word
//   input   | in_valid, in_ready, in_data    | one name character plus operation fields
//   result  | out_valid, out_ready, out_data | status, kind, value
//
// Characters are taken one per cycle while the front is ready. Add, evaluate-by-name,
// remove-locals and clean scan every table slot (one RAM row read per slot), a number is
// decoded digit by digit, and clear-all, other operation codes and errors on overlong
// names answer without a scan. Reset is synchronous and empties the table at once.
// The front stalls only when the queue holds a name and the back is busy or holds a result.
module scoped_symbol_table_evaluator #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NAME_CHARS    = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sst_pkg::sst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sst_pkg::sst_out_t out_data
);
  import sst_pkg::*;

  logic job_valid, job_ready;
  sst_job_t job;
  logic [NAME_CHARS-1:0][7:0] job_key;

  sst_front #(.NAME_CHARS(NAME_CHARS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .job_key   (job_key)
  );

  sst_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .NAME_CHARS(NAME_CHARS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .job_key   (job_key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

FILE: tb/sst_checker.sv
// Checker for the scoped symbol table evaluator: watches both channels,
// predicts each result word from its own table copy and compares. Depends on sst_pkg.
module sst_checker #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NAME_CHARS    = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  sst_pkg::sst_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  sst_pkg::sst_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  logic [7:0]  tbl_kind [TABLE_ENTRIES];
  logic [15:0] tbl_value [TABLE_ENTRIES];
  logic        tbl_local [TABLE_ENTRIES];
  int          tbl_len [TABLE_ENTRIES];
  logic [7:0]  tbl_name [TABLE_ENTRIES][NAME_CHARS];
  logic [7:0]  key [NAME_CHARS];
  int          key_len;
  logic        key_ovf;
  sst_out_t    expected_words [$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic bit key_match(input int s);
    if (tbl_len[s] != key_len) return 0;
    for (int j = 0; j < key_len; j++)
      if (tbl_name[s][j] != key[j]) return 0;
    return 1;
  endfunction

  function automatic int find_scope(input logic want_local);
    for (int s = 0; s < TABLE_ENTRIES; s++)
      if (tbl_kind[s] != 0 && tbl_local[s] == want_local && key_match(s)) return s;
    return -1;
  endfunction

  function automatic logic [2:0] add_symbol(input sst_in_t w);
    int s;
    s = 0;
    if (!w.new_is_local && find_scope(1'b0) >= 0) return ST_DUPLICATE;
    if (find_scope(1'b1) >= 0) return ST_DUPLICATE;
    while (s < TABLE_ENTRIES && tbl_kind[s] != 0) s++;
    if (s >= TABLE_ENTRIES) return ST_FULL;
    tbl_kind[s] = w.new_kind;
    tbl_value[s] = w.new_value;
    tbl_local[s] = w.new_is_local;
    tbl_len[s] = key_len;
    for (int j = 0; j < key_len; j++) tbl_name[s][j] = key[j];
    for (int j = 0; j < key_len; j++)
      if (!((key[j] >= "0" && key[j] <= "9") || (key[j] >= "a" && key[j] <= "z")
            || key[j] == ".")) return ST_BAD_IDENT;
    if (key_len == 1 && (key[0] == "r" || key[0] == "a" || key[0] == "y"))
      return ST_BAD_IDENT;
    return ST_OK;
  endfunction

  function automatic sst_out_t evaluate_key();
    sst_out_t r;
    int s, base, d, start;
    int unsigned acc;
    r = '0;
    if (key_len > 0 && (key[0] == "$" || (key[0] >= "0" && key[0] <= "9"))) begin
      base = (key[0] == "$") ? 16 : 10;
      start = (key[0] == "$") ? 1 : 0;
      acc = 0;
      for (int j = start; j < key_len; j++) begin
        if (key[j] >= "0" && key[j] <= "9") d = key[j] - "0";
        else if (key[j] >= "a" && key[j] <= "f") d = key[j] - "a" + 10;
        else d = 99;
        if (d >= base) begin
          r.status = ST_BAD_NUM;
          return r;
        end
        acc = acc * base + d;
        if (acc > NUM_MAX) begin
          r.status = ST_BAD_NUM;
          return r;
        end
      end
      r.found_value = acc[15:0];
      r.found_kind = (acc < 256) ? "B" : "W";
      return r;
    end
    s = find_scope(1'b1);
    if (s < 0) s = find_scope(1'b0);
    if (s < 0) r.status = ST_NOT_FOUND;
    else begin
      r.found_kind = tbl_kind[s];
      r.found_value = tbl_value[s];
    end
    return r;
  endfunction

  function automatic void predict_word(input sst_in_t w);
    logic [7:0] c;
    sst_out_t r;
    c = w.name_char;
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    if (key_len < NAME_CHARS) key[key_len++] = c;
    else key_ovf = 1;
    if (!w.last) return;
    r = '0;
    if (w.func == FUNC_ADD || w.func == FUNC_EVAL) begin
      if (key_ovf) r.status = ST_TOO_LONG;
      else if (w.func == FUNC_ADD) r.status = add_symbol(w);
      else r = evaluate_key();
    end else if (w.func == FUNC_RMLOC || w.func == FUNC_CLEAN || w.func == FUNC_CLRALL) begin
      for (int s = 0; s < TABLE_ENTRIES; s++)
        if (tbl_kind[s] != 0 && (w.func == FUNC_CLRALL || (w.func == FUNC_RMLOC && tbl_local[s])
            || (w.func == FUNC_CLEAN && tbl_len[s] > 0 && tbl_name[s][0] == ".")))
          tbl_kind[s] = 0;
    end
    if (r.status != ST_OK) begin
      r.found_kind = 0;
      r.found_value = 0;
    end
    key_len = 0;
    key_ovf = 0;
    expected_words.push_back(r);
  endfunction

  always @(posedge clk) begin
    sst_out_t e;
    if (!rst_n) begin
      for (int s = 0; s < TABLE_ENTRIES; s++) tbl_kind[s] = 0;
      key_len = 0;
      key_ovf = 0;
      expected_words.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (in_valid && in_ready) predict_word(in_data);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_words.size() == 0) report("unexpected word", out_data, 0);
        else begin
          e = expected_words.pop_front();
          if (out_data.status != e.status) report("status", out_data.status, e.status);
          if (out_data.found_kind != e.found_kind)
            report("found_kind", out_data.found_kind, e.found_kind);
          if (out_data.found_value != e.found_value)
            report("found_value", out_data.found_value, e.found_value);
        end
      end
    end
    pending = expected_words.size();
  end
endmodule

FILE: tb/scoped_symbol_table_evaluator_tb.sv
// Testbench top for the scoped symbol table evaluator: clock, reset, stimulus
// and verdict. Depends on sst_pkg, sst_checker and the block under test.
module scoped_symbol_table_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int NAME_CHARS = 32;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  sst_in_t in_data = '0;
  logic in_ready, out_valid;
  sst_out_t out_data;
  int fail_count, pending, results_seen;
  int words_sent = 0, ops_sent = 0;
  longint cycles = 0;
  bit no_idle = 0, hold_out = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  scoped_symbol_table_evaluator #(.TABLE_ENTRIES(TABLE_ENTRIES), .NAME_CHARS(NAME_CHARS)) u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data);

  sst_checker #(.TABLE_ENTRIES(TABLE_ENTRIES), .NAME_CHARS(NAME_CHARS)) u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending, .results_seen);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** scoped_symbol_table_evaluator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= rst_n && !hold_out && (no_idle || $urandom_range(99) >= 19);

  task automatic send_word(input sst_in_t w);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (w.last) ops_sent++;
  endtask

  task automatic send_op(input logic [2:0] f, input string text, input logic [7:0] kind,
                         input logic [15:0] value, input logic is_local);
    sst_in_t w;
    int n;
    n = (text.len() == 0) ? 1 : text.len();
    for (int i = 0; i < n; i++) begin
      w.func = f;
      w.name_char = (text.len() == 0) ? 8'h00 : text[i];
      w.last = (i == n - 1);
      w.new_kind = kind;
      w.new_value = value;
      w.new_is_local = is_local;
      send_word(w);
    end
  endtask

  function automatic string pick_name();
    string pool [8] = '{"lbl", ".l1", "Loop", "x", ".dot", "a1b2", "lbl9", "zz.q"};
    return pool[$urandom_range(7)];
  endfunction

  function automatic string rand_text(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(255)))};
    return s;
  endfunction

  function automatic string rand_number();
    case ($urandom_range(3))
      0: return $sformatf("%0d", $urandom_range(65535));
      1: return $sformatf("$%0h", $urandom_range(65535));
      2: return $sformatf("%0d", $urandom_range(99999));
      default: return $sformatf("$%0H", $urandom_range(1048575));
    endcase
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 20) @(posedge clk);
  endtask

  initial begin
    string t;
    int r;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_op(FUNC_EVAL, "nothere", 0, 0, 0);
    send_op(FUNC_ADD, "Start", "L", 16'hFFFF, 0);
    send_op(FUNC_ADD, "start", "L", 1, 0);
    send_op(FUNC_ADD, "start", "L", 2, 1);
    send_op(FUNC_ADD, ".loc", "C", 16'h0000, 1);
    send_op(FUNC_ADD, ".loc", "C", 3, 0);
    send_op(FUNC_EVAL, "START", 0, 0, 0);
    send_op(FUNC_ADD, "r", "X", 5, 0);
    send_op(FUNC_ADD, "b-c", 8'hFF, 7, 1);
    send_op(FUNC_ADD, "", 8'h01, 9, 0);
    send_op(FUNC_ADD, "zero", 8'h00, 9, 0);
    send_op(FUNC_EVAL, "zero", 0, 0, 0);
    send_op(FUNC_EVAL, "65535", 0, 0, 0);
    send_op(FUNC_EVAL, "65536", 0, 0, 0);
    send_op(FUNC_EVAL, "$ff", 0, 0, 0);
    send_op(FUNC_EVAL, "$", 0, 0, 0);
    send_op(FUNC_EVAL, "$1g", 0, 0, 0);
    send_op(FUNC_EVAL, "12a", 0, 0, 0);
    send_op(FUNC_ADD, "abcdefghijklmnopqrstuvwxyz0123456789", "L", 1, 0);
    send_op(FUNC_EVAL, "abcdefghijklmnopqrstuvwxyz0123456789", 0, 0, 0);
    send_op(FUNC_RMLOC, "q", 0, 0, 0);
    send_op(3'd5, "q", 0, 0, 0);
    send_op(3'd7, "q", 0, 0, 0);
    send_op(FUNC_CLEAN, "q", 0, 0, 0);
    send_op(FUNC_CLRALL, "q", 0, 0, 0);
    drain();
    // fill the table to overflow, with the receiver held off for a stretch;
    // one-character names, each added once global and once local
    fork
      begin
        hold_out = 1;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end
    join_none
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_op(FUNC_ADD, string'(byte'(128 + i / 2)), "L", 16'(i), i[0]);
    send_op(FUNC_ADD, "s", "L", 16'h0100, 0);
    send_op(FUNC_ADD, "t", "L", 16'h0101, 1);
    send_op(FUNC_EVAL, string'(byte'(131)), 0, 0, 0);
    send_op(FUNC_CLRALL, "", 0, 0, 0);
    drain();
    // random
    while (words_sent < 900) begin
      no_idle = (words_sent > 550 && words_sent < 750);
      r = $urandom_range(99);
      if (r < 35) send_op(FUNC_ADD, pick_name(), 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
      else if (r < 60) send_op(FUNC_EVAL, pick_name(), 0, 0, 0);
      else if (r < 75) send_op(FUNC_EVAL, rand_number(), 0, 0, 0);
      else if (r < 85) begin
        t = rand_text($urandom_range(1, 3));
        send_op($urandom_range(1) ? FUNC_ADD : FUNC_EVAL, t, 8'($urandom_range(255)),
                16'($urandom_range(65535)), 1'($urandom_range(1)));
      end else if (r < 88) send_op(FUNC_ADD, rand_text(34), 1, 1, 0);
      else if (r < 93) send_op(3'($urandom_range(2, 3)), "", 0, 0, 0);
      else if (r < 95) send_op(3'($urandom_range(4, 7)), rand_text(1), 0, 0, 0);
      else send_op(FUNC_EVAL, rand_text(6), 8'($urandom_range(255)),
                   16'($urandom_range(65535)), 1);
    end
    no_idle = 0;
    drain();
    $display("sent %0d words in %0d operations, checked %0d results", words_sent, ops_sent,
             results_seen);
    $display("covered adds, lookups, numbers, scope rules, full table, overlong names, clears");
    if (fail_count == 0 && pending == 0)
      $display("** scoped_symbol_table_evaluator: PASSED **");
    else
      $display("** scoped_symbol_table_evaluator: FAILED **");
    $finish;
  end
endmodule

FILE: sim.f
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/sst_front.sv
rtl/sst_back.sv
rtl/scoped_symbol_table_evaluator.sv
tb/sst_checker.sv
tb/scoped_symbol_table_evaluator_tb.sv
